### rtl/length_prefixed_packet_ring_fifo_core_assert.svh
// assertion macros used by the checker file of the packet ring fifo
// no dependencies; include by bare file name
`ifndef LENGTH_PREFIXED_PACKET_RING_FIFO_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_RING_FIFO_CORE_ASSERT_SVH

// same-cycle implication
`define LPRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lprf_pkg.sv
// types, codes and helper functions of the length-prefixed packet ring fifo
// no dependencies
package lprf_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int MAX_PACKET = 64;
    localparam int SIZE_W     = 11;
    localparam int LEN_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int RLEN_W     = 7;
    localparam int CMD_W      = 2;
    localparam int ST_W       = 2;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_ERR   = 2'd3;

    localparam logic [SIZE_W-1:0] RING_SIZE_MAX = SIZE_W'(RING_DEPTH);
    localparam logic [SIZE_W-1:0] RING_SIZE_MIN = SIZE_W'(2);

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [LEN_W-1:0]  packet_length;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic [ST_W-1:0]   status;
        logic [RLEN_W-1:0] returned_length;
        logic [SIZE_W-1:0] used_bytes;
    } t_out_item;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic              is_get;
        logic [ST_W-1:0]   status;
        logic [SIZE_W-1:0] used;
    } t_job;

    typedef struct packed {
        logic              en;
        logic [PTR_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] used;
    } t_get_done;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < RING_SIZE_MIN) r = RING_SIZE_MIN;
        if (v > RING_SIZE_MAX) r = RING_SIZE_MAX;
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] inc;
        logic [PTR_W-1:0]  r;
        inc = SIZE_W'(p) + SIZE_W'(1);
        if (inc >= size) r = '0;
        else             r = inc[PTR_W-1:0];
        return r;
    endfunction

endpackage

### rtl/lprf_ring_ram.sv
// generic single-write, single-read byte ram with registered read data
// no dependencies
module lprf_ring_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/lprf_job_queue.sv
// two-entry queue of result jobs between front and back
// depends on lprf_pkg
module lprf_job_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lprf_pkg::t_job  i_job,
    input  logic            i_pop,
    output lprf_pkg::t_job  o_job,
    output logic            o_full,
    output logic            o_empty
);

    lprf_pkg::t_job r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           n_wr_ptr;
    logic           n_rd_ptr;
    logic [1:0]     n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

### rtl/lprf_front.sv
// front end: accepts words, tracks packet write state, writes the ring, queues jobs
// depends on lprf_pkg
module lprf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lprf_pkg::t_in_item             i_in_item,
    input  logic                           i_cfg_we,
    input  logic [lprf_pkg::SIZE_W-1:0]    i_cfg_data,
    input  lprf_pkg::t_get_done            i_done,
    input  logic                           i_q_full,
    output logic                           o_push,
    output lprf_pkg::t_job                 o_job,
    output lprf_pkg::t_ram_wr              o_wr,
    output logic [lprf_pkg::SIZE_W-1:0]    o_ring_size
);

    logic [lprf_pkg::PTR_W-1:0]  r_wp, n_wp;
    logic [lprf_pkg::SIZE_W-1:0] r_used, n_used;
    logic [lprf_pkg::RLEN_W-1:0] r_remaining, n_remaining;
    logic                        r_open, n_open;
    logic                        r_dropping, n_dropping;
    logic                        r_get_pending, n_get_pending;
    logic [lprf_pkg::SIZE_W-1:0] r_ring_size, n_ring_size;

    logic                        accept;
    logic [lprf_pkg::SIZE_W-1:0] free_bytes;
    logic [lprf_pkg::SIZE_W-1:0] need_bytes;
    logic                        no_room;

    assign o_in_ready = !r_get_pending && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign free_bytes = r_ring_size - r_used;
    assign need_bytes = lprf_pkg::SIZE_W'(i_in_item.packet_length) + lprf_pkg::SIZE_W'(1);
    assign no_room    = (free_bytes <= need_bytes);

    always_comb begin
        n_wp          = r_wp;
        n_used        = r_used;
        n_remaining   = r_remaining;
        n_open        = r_open;
        n_dropping    = r_dropping;
        n_get_pending = r_get_pending;
        n_ring_size   = r_ring_size;
        o_push        = 1'b0;
        o_job         = '0;
        o_wr          = '0;

        if (accept) begin
            o_push      = 1'b1;
            o_job.used  = r_used;
            o_job.status = lprf_pkg::ST_OK;
            case (i_in_item.command)
                lprf_pkg::CMD_START: begin
                    if (r_open || r_dropping ||
                        i_in_item.packet_length > lprf_pkg::LEN_W'(lprf_pkg::MAX_PACKET)) begin
                        o_job.status = lprf_pkg::ST_ERR;
                    end else if (no_room) begin
                        o_job.status = lprf_pkg::ST_FULL;
                        if (i_in_item.packet_length != '0) begin
                            n_dropping  = 1'b1;
                            n_remaining = lprf_pkg::RLEN_W'(i_in_item.packet_length);
                        end
                    end else begin
                        // header byte holds the length
                        o_wr.en    = 1'b1;
                        o_wr.addr  = r_wp;
                        o_wr.data  = i_in_item.packet_length;
                        n_wp       = lprf_pkg::advance(r_wp, r_ring_size);
                        n_used     = r_used + lprf_pkg::SIZE_W'(1);
                        o_job.used = n_used;
                        if (i_in_item.packet_length != '0) begin
                            n_open      = 1'b1;
                            n_remaining = lprf_pkg::RLEN_W'(i_in_item.packet_length);
                        end
                    end
                end
                lprf_pkg::CMD_DATA: begin
                    if (r_open) begin
                        o_wr.en     = 1'b1;
                        o_wr.addr   = r_wp;
                        o_wr.data   = i_in_item.data_byte;
                        n_wp        = lprf_pkg::advance(r_wp, r_ring_size);
                        n_used      = r_used + lprf_pkg::SIZE_W'(1);
                        o_job.used  = n_used;
                        n_remaining = r_remaining - lprf_pkg::RLEN_W'(1);
                        if (r_remaining == lprf_pkg::RLEN_W'(1)) begin
                            n_open = 1'b0;
                        end
                    end else if (r_dropping) begin
                        o_job.status = lprf_pkg::ST_FULL;
                        n_remaining  = r_remaining - lprf_pkg::RLEN_W'(1);
                        if (r_remaining == lprf_pkg::RLEN_W'(1)) begin
                            n_dropping = 1'b0;
                        end
                    end else begin
                        o_job.status = lprf_pkg::ST_ERR;
                    end
                end
                lprf_pkg::CMD_GET: begin
                    if (r_open) begin
                        o_job.status = lprf_pkg::ST_ERR;
                    end else if (r_used == '0) begin
                        o_job.status = lprf_pkg::ST_EMPTY;
                    end else begin
                        // hold off input until the back end has read the whole packet
                        o_job.is_get  = 1'b1;
                        n_get_pending = 1'b1;
                    end
                end
                default: begin
                    o_job.status = lprf_pkg::ST_ERR;
                end
            endcase
        end

        if (i_done.done) begin
            n_used        = i_done.used;
            n_get_pending = 1'b0;
        end

        if (i_cfg_we) begin
            n_ring_size   = lprf_pkg::clamp_size(i_cfg_data);
            n_wp          = '0;
            n_used        = '0;
            n_remaining   = '0;
            n_open        = 1'b0;
            n_dropping    = 1'b0;
            n_get_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp          <= '0;
            r_used        <= '0;
            r_remaining   <= '0;
            r_open        <= 1'b0;
            r_dropping    <= 1'b0;
            r_get_pending <= 1'b0;
            r_ring_size   <= lprf_pkg::clamp_size(lprf_pkg::RING_SIZE_MAX);
        end else begin
            r_wp          <= n_wp;
            r_used        <= n_used;
            r_remaining   <= n_remaining;
            r_open        <= n_open;
            r_dropping    <= n_dropping;
            r_get_pending <= n_get_pending;
            r_ring_size   <= n_ring_size;
        end
    end

    assign o_ring_size = r_ring_size;

endmodule

### rtl/lprf_back.sv
// back end: drains queued jobs, reads packets out of the ring, drives the output register
// depends on lprf_pkg
module lprf_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lprf_pkg::SIZE_W-1:0]    i_ring_size,
    input  logic                           i_q_empty,
    input  lprf_pkg::t_job                 i_job,
    output logic                           o_pop,
    output logic                           o_rd_en,
    output logic [lprf_pkg::PTR_W-1:0]     o_rd_addr,
    input  logic [lprf_pkg::BYTE_W-1:0]    i_rd_data,
    output lprf_pkg::t_get_done            o_done,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lprf_pkg::t_out_item            o_out_item
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HDR   = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_ZERO  = 3'd4;

    logic [2:0]                  r_state, n_state;
    logic [lprf_pkg::PTR_W-1:0]  r_rp, n_rp;
    logic [lprf_pkg::PTR_W-1:0]  r_rp_end, n_rp_end;
    logic [lprf_pkg::RLEN_W-1:0] r_count, n_count;
    logic [lprf_pkg::RLEN_W-1:0] r_left, n_left;
    logic [lprf_pkg::SIZE_W-1:0] r_job_used, n_job_used;
    logic [lprf_pkg::SIZE_W-1:0] r_used_after, n_used_after;
    logic                        r_out_valid, n_out_valid;
    lprf_pkg::t_out_item         r_out, n_out;

    logic                        out_free;
    logic [lprf_pkg::RLEN_W-1:0] hdr_count;
    logic [lprf_pkg::SIZE_W-1:0] end_sum;

    assign out_free = !r_out_valid || i_out_ready;

    // header above the packet limit is saturated
    assign hdr_count = (i_rd_data > lprf_pkg::BYTE_W'(lprf_pkg::MAX_PACKET)) ?
                       lprf_pkg::RLEN_W'(lprf_pkg::MAX_PACKET) :
                       lprf_pkg::RLEN_W'(i_rd_data);
    assign end_sum   = lprf_pkg::SIZE_W'(r_rp) + lprf_pkg::SIZE_W'(r_count);

    always_comb begin
        n_state      = r_state;
        n_rp         = r_rp;
        n_rp_end     = r_rp_end;
        n_count      = r_count;
        n_left       = r_left;
        n_job_used   = r_job_used;
        n_used_after = r_used_after;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        o_pop        = 1'b0;
        o_rd_en      = 1'b0;
        o_done       = '0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_job.is_get) begin
                        // header read at the read pointer
                        o_pop      = 1'b1;
                        o_rd_en    = 1'b1;
                        n_job_used = i_job.used;
                        n_state    = S_HDR;
                    end else if (out_free) begin
                        o_pop                 = 1'b1;
                        n_out_valid           = 1'b1;
                        n_out.out_byte        = '0;
                        n_out.last            = 1'b1;
                        n_out.status          = i_job.status;
                        n_out.returned_length = '0;
                        n_out.used_bytes      = i_job.used;
                    end
                end
            end
            S_HDR: begin
                n_count = hdr_count;
                n_left  = hdr_count;
                n_rp    = lprf_pkg::advance(r_rp, i_ring_size);
                n_state = S_SETUP;
            end
            S_SETUP: begin
                if (end_sum >= i_ring_size) begin
                    n_rp_end = lprf_pkg::PTR_W'(end_sum - i_ring_size);
                end else begin
                    n_rp_end = lprf_pkg::PTR_W'(end_sum);
                end
                n_used_after = r_job_used - lprf_pkg::SIZE_W'(r_count) - lprf_pkg::SIZE_W'(1);
                if (r_count == '0) begin
                    n_state = S_ZERO;
                end else begin
                    o_rd_en = 1'b1;
                    n_rp    = lprf_pkg::advance(r_rp, i_ring_size);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.out_byte        = i_rd_data;
                    n_out.last            = (r_left == lprf_pkg::RLEN_W'(1));
                    n_out.status          = lprf_pkg::ST_OK;
                    n_out.returned_length = r_count;
                    n_out.used_bytes      = r_used_after;
                    if (r_left == lprf_pkg::RLEN_W'(1)) begin
                        o_done.done = 1'b1;
                        o_done.used = r_used_after;
                        n_rp        = r_rp_end;
                        n_state     = S_IDLE;
                    end else begin
                        o_rd_en = 1'b1;
                        n_rp    = lprf_pkg::advance(r_rp, i_ring_size);
                        n_left  = r_left - lprf_pkg::RLEN_W'(1);
                    end
                end
            end
            S_ZERO: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.out_byte        = '0;
                    n_out.last            = 1'b1;
                    n_out.status          = lprf_pkg::ST_OK;
                    n_out.returned_length = '0;
                    n_out.used_bytes      = r_used_after;
                    o_done.done           = 1'b1;
                    o_done.used           = r_used_after;
                    n_rp                  = r_rp_end;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_rp    = '0;
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rp_end     <= n_rp_end;
        r_count      <= n_count;
        r_left       <= n_left;
        r_job_used   <= n_job_used;
        r_used_after <= n_used_after;
        r_out        <= n_out;
    end

    assign o_rd_addr   = r_rp;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### rtl/length_prefixed_packet_ring_fifo_core.sv
// Packet ring fifo: each packet is kept in a byte ring as a length byte and its data
// bytes. Start, data and get words are classified by the front end, which writes the
// ring and answers start and data words, so a stream of writes runs at one word per
// cycle while the job queue has room and no get is pending. A get holds off input
// until its packet has been read: the ring's single registered read port reads the
// header, a setup step follows, then the port returns one byte per cycle while the
// output side keeps up. A two-entry job queue and the output register let the two
// ends stall on their own. Writing ring_size (saturated to 2..1024) empties the ring;
// the ring memory needs no clearing pass after reset.
// depends on lprf_pkg, lprf_front, lprf_job_queue, lprf_back, lprf_ring_ram
module length_prefixed_packet_ring_fifo_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lprf_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lprf_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_we,
    input  logic [lprf_pkg::SIZE_W-1:0]    i_cfg_data
);

    lprf_pkg::t_job              push_job;
    lprf_pkg::t_job              head_job;
    lprf_pkg::t_ram_wr           ram_wr;
    lprf_pkg::t_get_done         get_done;
    logic                        push;
    logic                        pop;
    logic                        q_full;
    logic                        q_empty;
    logic [lprf_pkg::SIZE_W-1:0] ring_size;
    logic                        rd_en;
    logic [lprf_pkg::PTR_W-1:0]  rd_addr;
    logic [lprf_pkg::BYTE_W-1:0] rd_data;

    lprf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_done      (get_done),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job),
        .o_wr        (ram_wr),
        .o_ring_size (ring_size)
    );

    lprf_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lprf_ring_ram #(
        .DEPTH (lprf_pkg::RING_DEPTH),
        .WIDTH (lprf_pkg::BYTE_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr.en),
        .i_wr_addr (ram_wr.addr),
        .i_wr_data (ram_wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lprf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_ring_size (ring_size),
        .i_q_empty   (q_empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_done      (get_done),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### rtl/lprf_checker.sv
// port-level checks of the packet ring fifo, bound to the top level
// depends on lprf_pkg and length_prefixed_packet_ring_fifo_core_assert.svh
`include "length_prefixed_packet_ring_fifo_core_assert.svh"

module lprf_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  lprf_pkg::t_in_item             i_in_item,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  lprf_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_we
);

    // anything but a returned byte is a single word with zero byte and length
    `LPRF_ASSERT_NOW(a_status_word_shape, i_clk, i_rst_n, o_out_valid && (o_out_item.status != lprf_pkg::ST_OK), o_out_item.last && (o_out_item.out_byte == '0) && (o_out_item.returned_length == '0), "status word not shaped as a single result")

    // a word that is not the last of its run belongs to a nonempty packet
    `LPRF_ASSERT_NOW(a_run_length, i_clk, i_rst_n, o_out_valid && !o_out_item.last, (o_out_item.status == lprf_pkg::ST_OK) && (o_out_item.returned_length != '0) && (o_out_item.returned_length <= lprf_pkg::RLEN_W'(lprf_pkg::MAX_PACKET)), "bad packet word inside a run")

    // within one packet the length and used count do not change
    `LPRF_ASSERT_NEXT(a_run_steady, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out_item.last, !o_out_valid || ((o_out_item.status == lprf_pkg::ST_OK) && (o_out_item.returned_length == $past(o_out_item.returned_length)) && (o_out_item.used_bytes == $past(o_out_item.used_bytes))), "packet run changed length or used count")

    // a stalled result word holds
    `LPRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready && !i_cfg_we, o_out_valid && $stable(o_out_item), "output word changed while stalled")

    // a waiting input word holds
    `LPRF_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_item), "input word changed while waiting")

endmodule

bind length_prefixed_packet_ring_fifo_core lprf_checker u_lprf_checker (.*);
